FILE: rtl/pree_pkg.sv
// Shared widths, codes and types of the particle ring emit/expire unit.
package pree_pkg;

  localparam int RING_DEPTH = 128;

  localparam int CLOCK_W  = 48;
  localparam int STEP_W   = 24;
  localparam int RATE_W   = 12;
  localparam int PERIOD_W = 32;
  localparam int LIFE_W   = 32;
  localparam int CAP_W    = 8;
  localparam int COUNT_W  = 8;
  localparam int INDEX_W  = 7;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = STEP_W + RATE_W;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOLD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EMITTING = 3'd4;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_HOLD    = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COUNT_W-1:0] created;
    logic [CLOCK_W-1:0] clock;
  } cmd_t;

  typedef struct packed {
    logic [RATE_W-1:0]   rate;
    logic [PERIOD_W-1:0] period;
    logic [LIFE_W-1:0]   life;
    logic [CAP_W-1:0]    eff_cap;
    logic                emitting;
  } cfg_t;

endpackage

FILE: rtl/pree_if.sv
// Channel interfaces of the particle ring emit/expire unit.
interface pree_in_if import pree_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [STEP_W-1:0] time_step;
  modport source (output valid, mode, time_step, input ready);
  modport sink   (input valid, mode, time_step, output ready);
  modport mon    (input valid, ready, mode, time_step);
endinterface

interface pree_out_if import pree_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] created_count;
  logic [COUNT_W-1:0] expired_count;
  logic [INDEX_W-1:0] head_index;
  logic [INDEX_W-1:0] tail_index;
  logic [CLOCK_W-1:0] clock_now;
  modport source (output valid, created_count, expired_count, head_index, tail_index,
                  clock_now, input ready);
  modport sink   (input valid, created_count, expired_count, head_index, tail_index,
                  clock_now, output ready);
  modport mon    (input valid, ready, created_count, expired_count, head_index, tail_index,
                  clock_now);
endinterface

interface pree_cfg_if import pree_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/pree_front.sv
// Front end: accepts updates, advances the clock and emission accumulator.
module pree_front import pree_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pree_in_if.sink    in_if,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t             state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r;
  logic [STEP_W-1:0]   step_r;
  logic [PROD_W-1:0]   prod_r;
  logic [CLOCK_W-1:0]  clock_r, clock_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic [PROD_W:0]     sum;
  logic [PROD_W:0]     limit;
  logic [PROD_W:0]     clamped;
  logic [CLOCK_W-1:0]  clock_adv;
  logic                accept;

  always_comb begin
    in_if.ready = (state_r == F_IDLE);
    accept      = in_if.valid && in_if.ready;
    sum         = {1'b0, prod_r} + (PROD_W+1)'(frac_r);
    limit       = (PROD_W+1)'({cfg.eff_cap, {FRAC_W{1'b0}}});
    clamped     = (sum > limit) ? limit : sum;
    clock_adv   = clock_r + CLOCK_W'(step_r);

    q_cmd.op      = OP_HOLD;
    q_cmd.created = '0;
    q_cmd.clock   = clock_r;
    clock_nxt     = clock_r;
    frac_nxt      = frac_r;
    case (mode_r)
      MODE_ADVANCE: begin
        q_cmd.op    = OP_ADVANCE;
        q_cmd.clock = clock_adv;
        clock_nxt   = clock_adv;
        if (cfg.emitting) begin
          q_cmd.created = clamped[FRAC_W +: COUNT_W];
          frac_nxt      = clamped[FRAC_W-1:0];
        end
      end
      MODE_CLEAR: begin
        q_cmd.op    = OP_CLEAR;
        q_cmd.clock = '0;
        clock_nxt   = '0;
        frac_nxt    = '0;
      end
      default: begin
        q_cmd.op = OP_HOLD;
      end
    endcase

    q_push    = (state_r == F_PUSH) && !q_full;
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      clock_r <= '0;
      frac_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_push) begin
        clock_r <= clock_nxt;
        frac_r  <= frac_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_if.mode;
      step_r <= in_if.time_step;
    end
    if (state_r == F_MUL) begin
      prod_r <= PROD_W'(step_r) * PROD_W'(cfg.rate);
    end
  end

endmodule

FILE: rtl/pree_queue.sv
// Two-entry command queue between front and back end.
module pree_queue import pree_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_cmd = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_cmd;
  end

endmodule

FILE: rtl/pree_back.sv
// Back end: writes birth times at the tail, expires from the head, emits results.
module pree_back import pree_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       cap_wr,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  pree_out_if.source out_if
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CW    = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_WRITE = 5'b00010,
    B_READ  = 5'b00100,
    B_SCAN  = 5'b01000,
    B_DONE  = 5'b10000
  } bstate_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [CAP_W-1:0] cap);
    logic [CW-1:0] n;
    n = CW'(p) + CW'(1);
    ptr_inc = (n >= CW'(cap)) ? '0 : n[PTR_W-1:0];
  endfunction

  logic [CLOCK_W-1:0] mem [RING_DEPTH];
  logic [CLOCK_W-1:0] rd_data_r;

  bstate_t             state_r, state_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [CLOCK_W-1:0]  clock_r, clock_nxt;
  logic [CLOCK_W-1:0]  birth_r, birth_nxt;
  logic [COUNT_W-1:0]  remain_r, remain_nxt;
  logic [COUNT_W-1:0]  created_r, created_nxt;
  logic [COUNT_W-1:0]  expired_r, expired_nxt;
  logic                mem_we;
  logic                out_load;
  logic                expire;
  logic [CLOCK_W:0]    ends;

  logic                out_valid_r;
  logic [COUNT_W-1:0]  out_created_r;
  logic [COUNT_W-1:0]  out_expired_r;
  logic [INDEX_W-1:0]  out_head_r;
  logic [INDEX_W-1:0]  out_tail_r;
  logic [CLOCK_W-1:0]  out_clock_r;

  assign out_if.valid         = out_valid_r;
  assign out_if.created_count = out_created_r;
  assign out_if.expired_count = out_expired_r;
  assign out_if.head_index    = out_head_r;
  assign out_if.tail_index    = out_tail_r;
  assign out_if.clock_now     = out_clock_r;

  always_comb begin
    ends   = {1'b0, rd_data_r} + (CLOCK_W+1)'(cfg.life);
    expire = (head_r != tail_r) && (ends < {1'b0, clock_r});

    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    clock_nxt   = clock_r;
    birth_nxt   = birth_r;
    remain_nxt  = remain_r;
    created_nxt = created_r;
    expired_nxt = expired_r;
    mem_we      = 1'b0;
    q_pop       = 1'b0;
    out_load    = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          clock_nxt   = q_cmd.clock;
          created_nxt = '0;
          expired_nxt = '0;
          case (q_cmd.op)
            OP_ADVANCE: begin
              created_nxt = q_cmd.created;
              remain_nxt  = q_cmd.created;
              birth_nxt   = q_cmd.clock;
              state_nxt   = (q_cmd.created != '0) ? B_WRITE : B_READ;
            end
            OP_CLEAR: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              state_nxt = B_DONE;
            end
            default: state_nxt = B_DONE;
          endcase
        end
      end
      B_WRITE: begin
        mem_we     = 1'b1;
        tail_nxt   = ptr_inc(tail_r, cfg.eff_cap);
        birth_nxt  = birth_r + CLOCK_W'(cfg.period);
        remain_nxt = remain_r - COUNT_W'(1);
        if (remain_r == COUNT_W'(1)) state_nxt = B_READ;
      end
      B_READ: state_nxt = B_SCAN;
      B_SCAN: begin
        if (expire) begin
          expired_nxt = expired_r + COUNT_W'(1);
          head_nxt    = ptr_inc(head_r, cfg.eff_cap);
        end else begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    if (cap_wr) begin
      head_nxt = '0;
      tail_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[tail_r] <= birth_r;
    rd_data_r <= mem[head_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    clock_r   <= clock_nxt;
    birth_r   <= birth_nxt;
    remain_r  <= remain_nxt;
    created_r <= created_nxt;
    expired_r <= expired_nxt;
    if (out_load) begin
      out_created_r <= created_r;
      out_expired_r <= expired_r;
      out_head_r    <= INDEX_W'(head_r);
      out_tail_r    <= INDEX_W'(tail_r);
      out_clock_r   <= clock_r;
    end
  end

endmodule

FILE: rtl/particle_ring_emit_expire_unit.sv
// Top level of the particle ring emit/expire unit.
// One update is handled at a time end to end in each half: the front takes each update
// through accept, rate multiply and accumulate, and the back's time per update grows
// with created_count + expired_count, since it writes or examines one ring slot
// per cycle through the single birth-time memory; the back sets the update rate.
// A two-entry queue between the halves and the output register let the next update
// enter while a result waits to be taken.
// Birth-time memory is not cleared after reset; only slots between head and tail are read.
module particle_ring_emit_expire_unit import pree_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pree_in_if.sink    in_if,
  pree_out_if.source out_if,
  pree_cfg_if.sink   cfg_if
);

  logic [RATE_W-1:0]   rate_r;
  logic [PERIOD_W-1:0] period_r;
  logic [LIFE_W-1:0]   life_r;
  logic [CAP_W-1:0]    cap_r;
  logic                emitting_r;
  logic [CAP_W-1:0]    eff_cap;
  logic                cfg_wr;
  logic                cap_wr;
  cfg_t                cfg;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_push_cmd, q_pop_cmd;

  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid && cfg_if.ready;
  assign cap_wr       = cfg_wr && (cfg_if.index == CFG_CAPACITY);

  always_comb begin
    if (cap_r == '0) eff_cap = CAP_W'(1);
    else if (int'(cap_r) > RING_DEPTH) eff_cap = CAP_W'(RING_DEPTH);
    else eff_cap = cap_r;
    cfg.rate     = rate_r;
    cfg.period   = period_r;
    cfg.life     = life_r;
    cfg.eff_cap  = eff_cap;
    cfg.emitting = emitting_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= RATE_W'(5);
      period_r   <= PERIOD_W'(13107);
      life_r     <= LIFE_W'(655360);
      cap_r      <= CAP_W'(100);
      emitting_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_if.index)
        CFG_RATE:     rate_r     <= cfg_if.data[RATE_W-1:0];
        CFG_PERIOD:   period_r   <= cfg_if.data[PERIOD_W-1:0];
        CFG_LIFETIME: life_r     <= cfg_if.data[LIFE_W-1:0];
        CFG_CAPACITY: cap_r      <= cfg_if.data[CAP_W-1:0];
        CFG_EMITTING: emitting_r <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  pree_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  pree_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .empty    (q_empty)
  );

  pree_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .cap_wr  (cap_wr),
    .q_empty (q_empty),
    .q_cmd   (q_pop_cmd),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

FILE: rtl/pree_checker.sv
// Port-level checks of the particle ring emit/expire unit and their binding.
module pree_checker import pree_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] out_created,
  input logic [COUNT_W-1:0] out_expired,
  input logic [INDEX_W-1:0] out_head,
  input logic [INDEX_W-1:0] out_tail,
  input logic [CLOCK_W-1:0] out_clock
);

  a_out_hold: assert property (@(posedge clk)
    rst_n && out_valid && !out_ready |=> !rst_n || out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk)
    rst_n && out_valid && !out_ready |=> !rst_n ||
      ($stable(out_created) && $stable(out_expired) &&
       $stable(out_head) && $stable(out_tail) &&
       $stable(out_clock)))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("front took a second item before finishing the first");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind particle_ring_emit_expire_unit pree_checker u_pree_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_created (out_if.created_count),
  .out_expired (out_if.expired_count),
  .out_head    (out_if.head_index),
  .out_tail    (out_if.tail_index),
  .out_clock   (out_if.clock_now)
);
